### design/dzfs_pkg.sv
package dzfs_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam int POS_W   = 32;
   localparam int DZ_W    = 31;
   localparam int FRAC_W  = 17;
   localparam int LEVEL_W = 24;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic [FRAC_W-1:0] SMOOTHING_RST = 17'd16384;
   localparam logic [FRAC_W-1:0] DECAY_RST     = 17'd58982;

   typedef enum logic [1:0] {
      OP_SET    = 2'd0,
      OP_SHAKE  = 2'd1,
      OP_FOLLOW = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DEADZONE_X = 3'd0,
      CSR_DEADZONE_Y = 3'd1,
      CSR_MIN_X      = 3'd2,
      CSR_MAX_X      = 3'd3,
      CSR_MIN_Y      = 3'd4,
      CSR_MAX_Y      = 3'd5,
      CSR_SMOOTHING  = 3'd6,
      CSR_DECAY      = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic signed [POS_W-1:0] track_x;
      logic signed [POS_W-1:0] track_y;
      logic signed [POS_W-1:0] impulse_x;
      logic signed [POS_W-1:0] impulse_y;
      logic [LEVEL_W-1:0]      level;
   } follow_state_type;

endpackage

### design/deadzone_follow_smoother.sv
// a request word passes the input stage, the state/snapshot stage and the response register
// throughput: one word per cycle unless the response stalls; the state update (deadzone,
// clamp, a 33x17 multiply per axis) is combinational; the view multiply is the next stage
// reset: synchronous; clears the tracked point, impulses and shake level to zero and
// loads the register defaults; no clearing pass, ready as soon as reset is released
module deadzone_follow_smoother
   import dzfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // csr write port
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // pos_x, pos_y, strength
   input  logic [1:0]            req_tuser,  // opcode
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // view_x, view_y, shaking, zero fill
);

   localparam int FRAC_BITS = FRAC_BITS_DEF;
   localparam logic [24:0] ONE = 25'(1) << FRAC_BITS;
   localparam int THRESH = (2 ** FRAC_BITS + 9999) / 10000;
   localparam int PROD_W = POS_W + LEVEL_W + 1;
   localparam logic signed [PROD_W+1:0] VIEW_MAX = (PROD_W+2)'(POS_MAX);
   localparam logic signed [PROD_W+1:0] VIEW_MIN = (PROD_W+2)'(POS_MIN);

   // configuration registers
   logic [DZ_W-1:0]         deadzone_x_ff, deadzone_y_ff;
   logic signed [POS_W-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic [FRAC_W-1:0]       smoothing_ff, decay_ff;

   // input stage
   logic                    a_valid_ff;
   op_type                  a_op_ff;
   logic signed [POS_W-1:0] a_px_ff, a_py_ff;
   logic [LEVEL_W-1:0]      a_str_ff;

   // running state and the snapshot handed to the view stage
   follow_state_type state_ff, state_in;
   follow_state_type b_snap_ff;
   logic             b_valid_ff;

   // response register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic en_out, en_b, en_a;
   logic [FRAC_W-1:0]  s_frac, dec_frac;
   logic [LEVEL_W-1:0] level_decayed;
   logic signed [POS_W-1:0] view_x, view_y;

   function automatic logic signed [POS_W-1:0] follow_axis(
      input logic signed [POS_W-1:0] trk,
      input logic signed [POS_W-1:0] focus,
      input logic [DZ_W-1:0]         dz,
      input logic signed [POS_W-1:0] lo,
      input logic signed [POS_W-1:0] hi,
      input logic [FRAC_W-1:0]       s
   );
      logic signed [POS_W:0]          d, des, diff, trk_w, focus_w, dz_w;
      logic [POS_W:0]                 mag;
      logic signed [POS_W+FRAC_W:0]   prod, step;
      logic signed [POS_W+1:0]        sum;
      trk_w   = (POS_W+1)'(trk);
      focus_w = (POS_W+1)'(focus);
      dz_w    = $signed({2'b00, dz});
      d       = focus_w - trk_w;
      mag     = d[POS_W] ? $unsigned(-d) : $unsigned(d);
      des     = trk_w;
      if (mag > $unsigned(dz_w)) begin
         des = d[POS_W] ? focus_w + dz_w : focus_w - dz_w;
      end
      // max is applied last so an inverted box resolves to the max bound
      if (des < (POS_W+1)'(lo)) begin
         des = (POS_W+1)'(lo);
      end
      if (des > (POS_W+1)'(hi)) begin
         des = (POS_W+1)'(hi);
      end
      diff = des - trk_w;
      prod = (POS_W+FRAC_W+1)'(diff) * (POS_W+FRAC_W+1)'($signed({1'b0, s}));
      step = prod >>> FRAC_BITS;
      sum  = (POS_W+2)'(trk) + (POS_W+2)'(step);
      return sum[POS_W-1:0];
   endfunction

   function automatic logic signed [POS_W-1:0] view_axis(
      input logic signed [POS_W-1:0] trk,
      input logic signed [POS_W-1:0] imp,
      input logic [LEVEL_W-1:0]      lvl
   );
      logic signed [PROD_W-1:0] prod;
      logic signed [PROD_W+1:0] sum;
      logic signed [POS_W-1:0]  res;
      prod = PROD_W'(imp) * PROD_W'($signed({1'b0, lvl}));
      sum  = (PROD_W+2)'(trk) + (PROD_W+2)'(prod >>> FRAC_BITS);
      if (sum > VIEW_MAX) begin
         res = POS_MAX;
      end else if (sum < VIEW_MIN) begin
         res = POS_MIN;
      end else begin
         res = sum[POS_W-1:0];
      end
      return res;
   endfunction

   // pipeline flow: each stage moves when the one after it can take its word
   assign en_out     = !rsp_valid_ff || rsp_tready;
   assign en_b       = !b_valid_ff || en_out;
   assign en_a       = !a_valid_ff || en_b;
   assign req_tready = en_a;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_x_ff <= '0;
         deadzone_y_ff <= '0;
         min_x_ff      <= POS_MIN;
         max_x_ff      <= POS_MAX;
         min_y_ff      <= POS_MIN;
         max_y_ff      <= POS_MAX;
         smoothing_ff  <= SMOOTHING_RST;
         decay_ff      <= DECAY_RST;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_DEADZONE_X: deadzone_x_ff <= csr_wdata[DZ_W-1:0];
            CSR_DEADZONE_Y: deadzone_y_ff <= csr_wdata[DZ_W-1:0];
            CSR_MIN_X:      min_x_ff      <= $signed(csr_wdata);
            CSR_MAX_X:      max_x_ff      <= $signed(csr_wdata);
            CSR_MIN_Y:      min_y_ff      <= $signed(csr_wdata);
            CSR_MAX_Y:      max_y_ff      <= $signed(csr_wdata);
            CSR_SMOOTHING:  smoothing_ff  <= csr_wdata[FRAC_W-1:0];
            CSR_DECAY:      decay_ff      <= csr_wdata[FRAC_W-1:0];
            default: ;
         endcase
      end
   end

   // fractions above one act as one
   assign s_frac   = ({8'b0, smoothing_ff} > ONE) ? ONE[FRAC_W-1:0] : smoothing_ff;
   assign dec_frac = ({8'b0, decay_ff} > ONE) ? ONE[FRAC_W-1:0] : decay_ff;
   assign level_decayed =
      LEVEL_W'((41'(state_ff.level) * 41'(dec_frac)) >> FRAC_BITS);

   always_comb begin
      state_in = state_ff;
      case (a_op_ff)
         OP_SET: begin
            state_in.track_x   = a_px_ff;
            state_in.track_y   = a_py_ff;
            state_in.impulse_x = '0;
            state_in.impulse_y = '0;
            state_in.level     = '0;
         end
         OP_SHAKE: begin
            state_in.impulse_x = a_px_ff;
            state_in.impulse_y = a_py_ff;
            if (a_str_ff > state_ff.level) begin
               state_in.level = a_str_ff;
            end
         end
         OP_FOLLOW: begin
            state_in.track_x = follow_axis(state_ff.track_x, a_px_ff, deadzone_x_ff,
                                           min_x_ff, max_x_ff, s_frac);
            state_in.track_y = follow_axis(state_ff.track_y, a_py_ff, deadzone_y_ff,
                                           min_y_ff, max_y_ff, s_frac);
            state_in.level   = level_decayed;
            // weaker than 0.0001 counts as no shake
            if (level_decayed < LEVEL_W'(THRESH)) begin
               state_in.level     = '0;
               state_in.impulse_x = '0;
               state_in.impulse_y = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en_a) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a && req_tvalid) begin
         a_op_ff  <= op_type'(req_tuser);
         a_px_ff  <= $signed(req_tdata[31:0]);
         a_py_ff  <= $signed(req_tdata[63:32]);
         a_str_ff <= req_tdata[87:64];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         if (en_b) begin
            b_valid_ff <= a_valid_ff;
         end
         if (en_b && a_valid_ff) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_b && a_valid_ff) begin
         b_snap_ff <= state_in;
      end
   end

   assign view_x = view_axis(b_snap_ff.track_x, b_snap_ff.impulse_x, b_snap_ff.level);
   assign view_y = view_axis(b_snap_ff.track_y, b_snap_ff.impulse_y, b_snap_ff.level);
   assign rsp_data_in = {7'b0, (b_snap_ff.level != '0), view_y, view_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out && b_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // a set-position word leaves no shake behind
   a_set_clears_shake: assert property (@(posedge clock) disable iff (reset)
      en_b && a_valid_ff && a_op_ff == OP_SET |=> state_ff.level == '0)
      else $error("shake level not cleared by set position");

   // a follow word never leaves a residual shake below the threshold
   a_follow_threshold: assert property (@(posedge clock) disable iff (reset)
      en_b && a_valid_ff && a_op_ff == OP_FOLLOW
      |=> state_ff.level == '0 || state_ff.level >= LEVEL_W'(THRESH))
      else $error("shake level left below threshold");

   // the shaking flag follows the snapshot it was computed from
   a_shaking_flag: assert property (@(posedge clock) disable iff (reset)
      en_out && b_valid_ff |=> rsp_tdata[64] == ($past(b_snap_ff.level) != '0))
      else $error("shaking flag mismatch");

   // a word held in the view stage is neither dropped nor changed while stalled
   a_hold_snapshot: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !en_b |=> b_valid_ff && $stable(b_snap_ff))
      else $error("view stage lost its word under stall");

endmodule
